FILE: rtl/gab_pkg.sv
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types and codes for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package gab_pkg;

   localparam int COL_W = 6;

   localparam logic [2:0] MODE_WR_A   = 3'd0;
   localparam logic [2:0] MODE_WR_B   = 3'd1;
   localparam logic [2:0] MODE_WR_C   = 3'd2;
   localparam logic [2:0] MODE_RUN    = 3'd3;
   localparam logic [2:0] MODE_RD_C   = 3'd4;

   localparam logic [2:0] REG_ROWS_M  = 3'd0;
   localparam logic [2:0] REG_COLS_N  = 3'd1;
   localparam logic [2:0] REG_INNER_K = 3'd2;
   localparam logic [2:0] REG_ALPHA   = 3'd3;
   localparam logic [2:0] REG_BETA    = 3'd4;
   localparam logic [2:0] REG_A_TRANS = 3'd5;
   localparam logic [2:0] REG_B_TRANS = 3'd6;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [COL_W-1:0]   col;
      logic signed [63:0] prod;
   } tok_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_FEED,
      S_DRAIN,
      S_P0,
      S_P1,
      S_P2,
      S_P3,
      S_P4,
      S_DONE
   } state_type;

   typedef struct packed {
      logic feed;
      logic drain;
      logic shift;
      logic c_wr;
   } ctl_type;

endpackage

FILE: rtl/gab_cell.sv
// ----------------------------------------------------------------------------
// gab_cell
// Accumulator cell: sums products tagged with its column, forwards tokens,
// and shifts its sum toward the chain head on request.
// ----------------------------------------------------------------------------
module gab_cell
   import gab_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int ACC_W = 69
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tok_type                 tok_in,
   output tok_type                 tok_out,
   input  logic                    shift_en,
   input  logic signed [ACC_W-1:0] acc_in,
   output logic signed [ACC_W-1:0] acc_out
);

   tok_type                 tok_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    hit;

   assign hit     = tok_in.valid && (tok_in.col == COL_W'(INDEX));
   assign tok_out = tok_ff;
   assign acc_out = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         acc_ff       <= '0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         if (shift_en) begin
            acc_ff <= acc_in;
         end else if (hit) begin
            acc_ff <= acc_ff + ACC_W'(tok_in.prod);
         end
      end
      tok_ff.col  <= tok_in.col;
      tok_ff.prod <= tok_in.prod;
   end

endmodule

FILE: rtl/gemm_alpha_beta_transpose.sv
// ----------------------------------------------------------------------------
// gemm_alpha_beta_transpose
// Q16.16 matrix multiply C = alpha*op(A)*op(B) + beta*C on element stores.
//
//   channel | direction | ports
//   req     | in        | req_mode, req_elem_index, req_elem_value
//   rsp     | out       | rsp_kind, rsp_out_index, rsp_out_value
//   csr     | in        | csr_index, csr_data
//
// Store writes take effect on the accepted request; a C read goes through
// a store register to the result register and waits for a free result
// register. A compute feeds one product per cycle into the cell chain (no
// products when k is zero, straight to done when m or n is zero), drains
// each row through MAX_DIM cells, then takes five scaling steps per element.
// Reset clears control and accumulators; store contents stay undefined.
// ----------------------------------------------------------------------------
module gemm_alpha_beta_transpose
   import gab_pkg::*;
#(
   parameter int MAX_DIM   = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [7:0]         rsp_out_index,
   output logic signed [31:0] rsp_out_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = $clog2(MAX_DIM + 1);
   localparam int ACC_W  = 65 + $clog2(MAX_DIM);
   localparam int SW     = ACC_W - FRAC_BITS;
   localparam int HW     = (SW + 1) / 2;
   localparam int TW     = SW + 33;
   localparam int DRN    = MAX_DIM + 3;
   localparam int DRW    = $clog2(DRN + 1);

   logic [4:0]         rows_m_ff, cols_n_ff, inner_k_ff;
   logic signed [31:0] alpha_ff, beta_ff;
   logic               a_tr_ff, b_tr_ff;

   logic [31:0] a_mem [DEPTH];
   logic [31:0] b_mem [DEPTH];
   logic [31:0] c_mem [DEPTH];

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [DW-1:0]  m_eff, n_eff, k_eff;
   logic [DW-1:0]  mi_ff, ni_ff, ki_ff;
   logic [DRW-1:0] drain_ff;
   logic           feed_last, row_last, all_last;

   logic [2*DW-1:0] a_lin, b_lin, c_lin;
   logic [AW-1:0]   req_addr, c_raddr;
   logic            req_ok, req_fire;

   logic signed [31:0] a_rd_ff, b_rd_ff, c_rd_ff;
   logic               v1_ff;
   logic [COL_W-1:0]   col1_ff;
   tok_type            tok2_ff;

   tok_type                 tok_chain [MAX_DIM+1];
   logic signed [ACC_W-1:0] acc_chain [MAX_DIM+1];

   logic signed [SW-1:0]       sh_ff;
   logic signed [HW+32:0]      plo_ff;
   logic signed [SW-HW+31:0]   phi_ff;
   logic signed [TW-1:0]       sum_ff, full;
   logic signed [63:0]         bc_ff;
   logic signed [TW:0]         tot;
   logic [TW-31:0]             upper;
   logic signed [31:0]         sat;

   logic               rsp_valid_ff, rsp_kind_ff;
   logic [7:0]         rsp_index_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rd_ok_ff;
   logic [7:0]         rd_index_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= 5'd1;
         cols_n_ff  <= 5'd1;
         inner_k_ff <= 5'd1;
         alpha_ff   <= 32'sd65536;
         beta_ff    <= '0;
         a_tr_ff    <= 1'b0;
         b_tr_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROWS_M:  rows_m_ff  <= csr_data[4:0];
            REG_COLS_N:  cols_n_ff  <= csr_data[4:0];
            REG_INNER_K: inner_k_ff <= csr_data[4:0];
            REG_ALPHA:   alpha_ff   <= $signed(csr_data);
            REG_BETA:    beta_ff    <= $signed(csr_data);
            REG_A_TRANS: a_tr_ff    <= csr_data[0];
            REG_B_TRANS: b_tr_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign m_eff = (32'(rows_m_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(rows_m_ff);
   assign n_eff = (32'(cols_n_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cols_n_ff);
   assign k_eff = (32'(inner_k_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(inner_k_ff);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign req_ok    = 32'(req_elem_index) < DEPTH;
   assign req_addr  = AW'(req_elem_index);

   assign a_lin = a_tr_ff ? (2*DW)'(ki_ff * m_eff + mi_ff)
                          : (2*DW)'(mi_ff * k_eff + ki_ff);
   assign b_lin = b_tr_ff ? (2*DW)'(ni_ff * k_eff + ki_ff)
                          : (2*DW)'(ki_ff * n_eff + ni_ff);
   assign c_lin = (2*DW)'(mi_ff * n_eff + ni_ff);
   assign c_raddr = (state_ff == S_IDLE) ? req_addr : AW'(c_lin);

   assign feed_last = (ni_ff == n_eff - 1'b1) && ((k_eff == '0) || (ki_ff == k_eff - 1'b1));
   assign row_last  = (ni_ff == n_eff - 1'b1);
   assign all_last  = row_last && (mi_ff == m_eff - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_mode == MODE_RD_C) begin
               state_in = S_RD;
            end else if (req_fire && req_mode == MODE_RUN) begin
               state_in = (m_eff == '0 || n_eff == '0) ? S_DONE : S_FEED;
            end
         end
         S_RD:    state_in = S_IDLE;
         S_FEED:  if (feed_last) state_in = S_DRAIN;
         S_DRAIN: if (drain_ff == DRW'(DRN - 1)) state_in = S_P0;
         S_P0:    state_in = S_P1;
         S_P1:    state_in = S_P2;
         S_P2:    state_in = S_P3;
         S_P3:    state_in = S_P4;
         S_P4:    state_in = all_last ? S_DONE : (row_last ? S_FEED : S_P0);
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_FEED:  ctl.feed  = 1'b1;
         S_DRAIN: ctl.drain = 1'b1;
         S_P4: begin
            ctl.shift = 1'b1;
            ctl.c_wr  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mi_ff    <= '0;
         ni_ff    <= '0;
         ki_ff    <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE) begin
            mi_ff    <= '0;
            ni_ff    <= '0;
            ki_ff    <= '0;
            drain_ff <= '0;
         end else if (ctl.feed) begin
            if (row_last) begin
               ni_ff <= '0;
               ki_ff <= ki_ff + 1'b1;
            end else begin
               ni_ff <= ni_ff + 1'b1;
            end
            drain_ff <= '0;
         end else if (ctl.drain) begin
            drain_ff <= drain_ff + 1'b1;
         end else if (ctl.shift) begin
            if (row_last) begin
               ni_ff <= '0;
               ki_ff <= '0;
               mi_ff <= mi_ff + 1'b1;
            end else begin
               ni_ff <= ni_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_ok && req_mode == MODE_WR_A) a_mem[req_addr] <= req_elem_value;
      if (req_fire && req_ok && req_mode == MODE_WR_B) b_mem[req_addr] <= req_elem_value;
      if (req_fire && req_ok && req_mode == MODE_WR_C) begin
         c_mem[req_addr] <= req_elem_value;
      end else if (ctl.c_wr) begin
         c_mem[AW'(c_lin)] <= sat;
      end
      a_rd_ff <= a_mem[AW'(a_lin)];
      b_rd_ff <= b_mem[AW'(b_lin)];
      c_rd_ff <= c_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         tok2_ff.valid <= 1'b0;
      end else begin
         v1_ff         <= ctl.feed && (k_eff != '0);
         tok2_ff.valid <= v1_ff;
      end
      col1_ff      <= COL_W'(ni_ff);
      tok2_ff.col  <= col1_ff;
      tok2_ff.prod <= a_rd_ff * b_rd_ff;
   end

   assign tok_chain[0]       = tok2_ff;
   assign acc_chain[MAX_DIM] = '0;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      gab_cell #(
         .INDEX (j),
         .ACC_W (ACC_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_chain[j]),
         .tok_out  (tok_chain[j+1]),
         .shift_en (ctl.shift),
         .acc_in   (acc_chain[j+1]),
         .acc_out  (acc_chain[j])
      );
   end

   assign full  = (TW'(phi_ff) <<< HW) + TW'(plo_ff);
   assign tot   = (TW+1)'(sum_ff)
                + ((beta_ff != '0) ? (TW+1)'(bc_ff >>> FRAC_BITS) : '0);
   assign upper = tot[TW:31];
   assign sat   = (&upper || ~|upper) ? tot[31:0]
                : (tot[TW] ? 32'sh8000_0000 : 32'sh7fff_ffff);

   always_ff @(posedge clock) begin
      if (state_ff == S_P0) sh_ff  <= SW'(acc_chain[0] >>> FRAC_BITS);
      if (state_ff == S_P1) plo_ff <= $signed({1'b0, sh_ff[HW-1:0]}) * alpha_ff;
      if (state_ff == S_P2) phi_ff <= $signed(sh_ff[SW-1:HW]) * alpha_ff;
      if (state_ff == S_P3) begin
         sum_ff <= full >>> FRAC_BITS;
         bc_ff  <= beta_ff * c_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RD || state_ff == S_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         rd_ok_ff    <= req_ok;
         rd_index_ff <= req_elem_index;
      end
      if (state_ff == S_RD) begin
         rsp_kind_ff  <= KIND_READ;
         rsp_index_ff <= rd_index_ff;
         rsp_value_ff <= rd_ok_ff ? c_rd_ff : '0;
      end else if (state_ff == S_DONE) begin
         rsp_kind_ff  <= KIND_DONE;
         rsp_index_ff <= '0;
         rsp_value_ff <= '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;

   a_quiet_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P0) |-> !tok2_ff.valid && !v1_ff)
      else $error("product still in flight at scaling");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid_ff && (rsp_kind_ff == KIND_DONE))
      else $error("compute finish not reported");

   a_feed_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FEED) |-> (ni_ff < n_eff))
      else $error("column counter out of range");

endmodule
